[design/free_slip_velocity_projection_unit_macros.svh]
// Assertion macros for the free-slip velocity projection unit.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef FREE_SLIP_VELOCITY_PROJECTION_UNIT_MACROS_SVH
`define FREE_SLIP_VELOCITY_PROJECTION_UNIT_MACROS_SVH

// Checked only outside reset.
`define FSVP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define FSVP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/fsvp_pkg.sv]
// Shared widths, types and saturation helpers for the free-slip projection unit.
// No dependencies.
package fsvp_pkg;

  localparam int VELOCITY_WIDTH = 32;
  localparam int NORMAL_WIDTH   = 16;
  localparam int FRAC_N         = NORMAL_WIDTH - 2;
  localparam int PROD_W         = VELOCITY_WIDTH + NORMAL_WIDTH;
  localparam int WIDE_W         = PROD_W + 1;
  localparam int NSTAGE         = 7;

  typedef logic signed [VELOCITY_WIDTH-1:0] vel_t;
  typedef logic signed [NORMAL_WIDTH-1:0]   norm_t;
  typedef logic signed [PROD_W-1:0]         prod_t;
  typedef logic signed [WIDE_W-1:0]         wide_t;

  localparam vel_t VEL_MAX = vel_t'({1'b0, {(VELOCITY_WIDTH-1){1'b1}}});
  localparam vel_t VEL_MIN = vel_t'({1'b1, {(VELOCITY_WIDTH-1){1'b0}}});

  typedef enum logic [2:0] {
    CASE_INTERIOR = 3'd0,
    CASE_KEPT     = 3'd1,
    CASE_EDGE1    = 3'd2,
    CASE_EDGE2    = 3'd3,
    CASE_ZEROED   = 3'd4
  } case_t;

  typedef struct packed {
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] vld;
  } pipe_ctl_t;

  // Clamp a wide signed value into the velocity range.
  function automatic vel_t sat_vel(input wide_t x);
    logic [WIDE_W-VELOCITY_WIDTH:0] top;
    top = x[WIDE_W-1:VELOCITY_WIDTH-1];
    if ((&top) || (~|top)) begin
      return x[VELOCITY_WIDTH-1:0];
    end
    return x[WIDE_W-1] ? VEL_MIN : VEL_MAX;
  endfunction

  // Strictly positive.
  function automatic logic is_pos(input vel_t x);
    return !x[VELOCITY_WIDTH-1] && (x != '0);
  endfunction

endpackage

[design/fsvp_ctrl.sv]
// Valid bits and per-stage enables for the projection pipeline.
// Depends on fsvp_pkg.
module fsvp_ctrl
  import fsvp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_ready,
  output pipe_ctl_t ctl
);

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign ctl.en  = en;
  assign ctl.vld = vld;

endmodule

[design/fsvp_dot.sv]
// Two-stage fixed-point dot product: multiply, then sum, floor shift, saturate.
// Depends on fsvp_pkg.
module fsvp_dot
  import fsvp_pkg::*;
(
  input  logic       clk,
  input  logic [1:0] en,
  input  vel_t       u,
  input  vel_t       v,
  input  norm_t      nu,
  input  norm_t      nv,
  output vel_t       dot
);

  prod_t p_u;
  prod_t p_v;
  wide_t sum;
  wide_t sh;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_u <= u * nu;
      p_v <= v * nv;
    end
  end

  always_comb begin
    sum = wide_t'(p_u) + wide_t'(p_v);
    sh  = sum >>> FRAC_N;
  end

  always_ff @(posedge clk) begin
    if (en[1]) dot <= sat_vel(sh);
  end

endmodule

[design/fsvp_remove.sv]
// Two-stage removal of one normal component: x - floor(nvel * n >> F), saturated.
// Depends on fsvp_pkg.
module fsvp_remove
  import fsvp_pkg::*;
(
  input  logic       clk,
  input  logic [1:0] en,
  input  vel_t       x,
  input  vel_t       nvel,
  input  norm_t      n,
  output vel_t       res
);

  prod_t p;
  vel_t  x_q;
  prod_t p_sh;
  wide_t diff;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p   <= nvel * n;
      x_q <= x;
    end
  end

  always_comb begin
    p_sh = p >>> FRAC_N;
    diff = wide_t'(x_q) - wide_t'(p_sh);
  end

  always_ff @(posedge clk) begin
    if (en[1]) res <= sat_vel(diff);
  end

endmodule

[design/free_slip_velocity_projection_unit.sv]
// Top level of the free-slip velocity projection unit.
// Depends on fsvp_pkg, fsvp_ctrl, fsvp_dot, fsvp_remove and the assertion macro header.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   input   | in_valid / in_ready  | vel_u vel_v edge1_nu edge1_nv edge2_nu
//           |                      | edge2_nv is_interior
//   output  | out_valid / out_ready| out_u out_v case_taken
//
// One vertex per cycle sustained while out_ready holds.
// The latency is set by three dependent multiply levels (edge dots, projections,
// cross-check dots), each a multiply stage followed by an add/saturate stage,
// plus the output register that makes the case decision.
// Reset clears only the valid bits; no clearing pass.
// Each stage holds when it is full and the next one holds, so bubbles collapse
// and the input keeps taking transfers while a result waits at the output,
// until all seven stages are full; then in_ready drops.
`include "free_slip_velocity_projection_unit_macros.svh"

module free_slip_velocity_projection_unit
  import fsvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  vel_t        vel_u,
  input  vel_t        vel_v,
  input  norm_t       edge1_nu,
  input  norm_t       edge1_nv,
  input  norm_t       edge2_nu,
  input  norm_t       edge2_nv,
  input  logic        is_interior,
  output logic        out_valid,
  input  logic        out_ready,
  output vel_t        out_u,
  output vel_t        out_v,
  output logic [2:0]  case_taken
);

  // Data that rides alongside the arithmetic units, one copy per stage before the output register.
  typedef struct packed {
    vel_t  u;
    vel_t  v;
    norm_t n1u;
    norm_t n1v;
    norm_t n2u;
    norm_t n2v;
    logic  interior;
    logic  pos1;
    logic  pos2;
    vel_t  u1;
    vel_t  v1;
    vel_t  u2;
    vel_t  v2;
  } side_t;

  pipe_ctl_t ctl;
  side_t     side [6];
  side_t     side2_next;
  side_t     side4_next;

  vel_t  nv1;
  vel_t  nv2;
  vel_t  u1;
  vel_t  v1;
  vel_t  u2;
  vel_t  v2;
  vel_t  nv2t1;
  vel_t  nv1t2;
  case_t case_q;

  fsvp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  assign in_ready  = ctl.en[0];
  assign out_valid = ctl.vld[NSTAGE-1];

  // Stages 1-2: normal velocity on each edge.
  fsvp_dot u_dot1 (
    .clk (clk), .en (ctl.en[1:0]),
    .u (vel_u), .v (vel_v), .nu (edge1_nu), .nv (edge1_nv), .dot (nv1)
  );
  fsvp_dot u_dot2 (
    .clk (clk), .en (ctl.en[1:0]),
    .u (vel_u), .v (vel_v), .nu (edge2_nu), .nv (edge2_nv), .dot (nv2)
  );

  // Stages 3-4: velocity with each edge's normal part removed.
  fsvp_remove u_rm_u1 (
    .clk (clk), .en (ctl.en[3:2]),
    .x (side[1].u), .nvel (nv1), .n (side[1].n1u), .res (u1)
  );
  fsvp_remove u_rm_v1 (
    .clk (clk), .en (ctl.en[3:2]),
    .x (side[1].v), .nvel (nv1), .n (side[1].n1v), .res (v1)
  );
  fsvp_remove u_rm_u2 (
    .clk (clk), .en (ctl.en[3:2]),
    .x (side[1].u), .nvel (nv2), .n (side[1].n2u), .res (u2)
  );
  fsvp_remove u_rm_v2 (
    .clk (clk), .en (ctl.en[3:2]),
    .x (side[1].v), .nvel (nv2), .n (side[1].n2v), .res (v2)
  );

  // Stages 5-6: does each projection clear the other edge?
  fsvp_dot u_dot2t1 (
    .clk (clk), .en (ctl.en[5:4]),
    .u (u1), .v (v1), .nu (side[3].n2u), .nv (side[3].n2v), .dot (nv2t1)
  );
  fsvp_dot u_dot1t2 (
    .clk (clk), .en (ctl.en[5:4]),
    .u (u2), .v (v2), .nu (side[3].n1u), .nv (side[3].n1v), .dot (nv1t2)
  );

  // Sideband words for the stages that add fields.
  always_comb begin
    side2_next      = side[1];
    side2_next.pos1 = is_pos(nv1);
    side2_next.pos2 = is_pos(nv2);
    side4_next      = side[3];
    side4_next.u1   = u1;
    side4_next.v1   = v1;
    side4_next.u2   = u2;
    side4_next.v2   = v2;
  end

  // Sideband pipeline; fields are filled in at the stage that produces them.
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      side[0].u        <= vel_u;
      side[0].v        <= vel_v;
      side[0].n1u      <= edge1_nu;
      side[0].n1v      <= edge1_nv;
      side[0].n2u      <= edge2_nu;
      side[0].n2v      <= edge2_nv;
      side[0].interior <= is_interior;
      side[0].pos1     <= 1'b0;
      side[0].pos2     <= 1'b0;
      side[0].u1       <= '0;
      side[0].v1       <= '0;
      side[0].u2       <= '0;
      side[0].v2       <= '0;
    end
    if (ctl.en[1]) side[1] <= side[0];
    if (ctl.en[2]) side[2] <= side2_next;
    if (ctl.en[3]) side[3] <= side[2];
    if (ctl.en[4]) side[4] <= side4_next;
    if (ctl.en[5]) side[5] <= side[4];
  end

  // Output register: pick the case, first match wins.
  always_ff @(posedge clk) begin
    if (ctl.en[6]) begin
      priority if (side[5].interior) begin
        out_u  <= side[5].u;
        out_v  <= side[5].v;
        case_q <= CASE_INTERIOR;
      end else if (!side[5].pos1 && !side[5].pos2) begin
        out_u  <= side[5].u;
        out_v  <= side[5].v;
        case_q <= CASE_KEPT;
      end else if (side[5].pos1 && !is_pos(nv2t1)) begin
        out_u  <= side[5].u1;
        out_v  <= side[5].v1;
        case_q <= CASE_EDGE1;
      end else if (side[5].pos2 && !is_pos(nv1t2)) begin
        out_u  <= side[5].u2;
        out_v  <= side[5].v2;
        case_q <= CASE_EDGE2;
      end else begin
        out_u  <= '0;
        out_v  <= '0;
        case_q <= CASE_ZEROED;
      end
    end
  end

  assign case_taken = case_q;

  // An empty output stage opens the whole pipe.
  `FSVP_ASSERT(a_empty_out_ready, !out_valid |-> in_ready, "input stalled with empty output")
  // Reset drains every stage; checked here at the output stage.
  `FSVP_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid, "result valid after reset")
  // A zeroed case carries a zero velocity.
  `FSVP_ASSERT(a_zeroed_vel, case_q == CASE_ZEROED |-> {out_u, out_v} == '0, "zeroed case not zero")

endmodule
